// File: rtl/iss_pkg.sv
// shared types and constants of the indexed sequence store
`default_nettype none

package iss_pkg;

    // fixed field widths
    localparam int REQ_W     = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_GET    = 3'd2,
        REQ_SET    = 3'd3,
        REQ_SIZE   = 3'd4,
        REQ_CLEAR  = 3'd5
    } req_t;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_PUT_VAL,
        S_SHIFT_DOWN,
        S_READ,
        S_FILL,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic            accept;
        logic            set_result;
        logic [ST_W-1:0] status;
        logic            load_ptr_count;
        logic            load_ptr_pos;
        logic            shift_up_step;
        logic            shift_down_step;
        logic            write_val;
        logic            fill_step;
        logic            read_pos;
        logic            capture_read;
        logic            count_inc;
        logic            count_dec;
        logic            count_set_tgt;
        logic            count_clear;
        logic            emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             pos_gt_cnt;
        logic             pos_ge_cnt;
        logic             cnt_full;
        logic             tgt_over;
        logic             tgt_gt_cnt;
        logic             ptr_gt_pos;
        logic             ptr_inc_lt_cnt;
        logic             ptr_lt_tgt;
        logic             out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/iss_ctrl.sv
// sequencing state machine of the indexed sequence store
`default_nettype none

module iss_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire iss_pkg::stat_t stat,
    output iss_pkg::cmd_t      cmd
);

    iss_pkg::state_t state_reg;
    iss_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iss_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            iss_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = iss_pkg::S_DECODE;
                end
            end
            iss_pkg::S_DECODE: begin
                cmd.set_result = 1'b1;
                cmd.status     = iss_pkg::ST_OK;
                state_next     = iss_pkg::S_RESP;
                case (stat.req_type)
                    iss_pkg::REQ_INSERT: begin
                        if (stat.pos_gt_cnt) begin
                            cmd.status = iss_pkg::ST_RANGE;
                        end else if (stat.cnt_full) begin
                            cmd.status = iss_pkg::ST_FULL;
                        end else begin
                            cmd.load_ptr_count = 1'b1;
                            state_next         = iss_pkg::S_SHIFT_UP;
                        end
                    end
                    iss_pkg::REQ_REMOVE: begin
                        if (stat.pos_ge_cnt) begin
                            cmd.status = iss_pkg::ST_RANGE;
                        end else begin
                            cmd.load_ptr_pos = 1'b1;
                            state_next       = iss_pkg::S_SHIFT_DOWN;
                        end
                    end
                    iss_pkg::REQ_GET: begin
                        if (stat.pos_ge_cnt) begin
                            cmd.status = iss_pkg::ST_RANGE;
                        end else begin
                            cmd.read_pos = 1'b1;
                            state_next   = iss_pkg::S_READ;
                        end
                    end
                    iss_pkg::REQ_SET: begin
                        if (stat.pos_ge_cnt) begin
                            cmd.status = iss_pkg::ST_RANGE;
                        end else begin
                            cmd.write_val = 1'b1;
                        end
                    end
                    iss_pkg::REQ_SIZE: begin
                        if (stat.tgt_over) begin
                            cmd.status = iss_pkg::ST_FULL;
                        end else if (stat.tgt_gt_cnt) begin
                            cmd.load_ptr_count = 1'b1;
                            state_next         = iss_pkg::S_FILL;
                        end else begin
                            cmd.count_set_tgt = 1'b1;
                        end
                    end
                    iss_pkg::REQ_CLEAR: begin
                        cmd.count_clear = 1'b1;
                    end
                    default: begin
                        // unused codes leave the state alone
                    end
                endcase
            end
            iss_pkg::S_SHIFT_UP: begin
                if (stat.ptr_gt_pos) begin
                    cmd.shift_up_step = 1'b1;
                end else begin
                    state_next = iss_pkg::S_PUT_VAL;
                end
            end
            iss_pkg::S_PUT_VAL: begin
                cmd.write_val = 1'b1;
                cmd.count_inc = 1'b1;
                state_next    = iss_pkg::S_RESP;
            end
            iss_pkg::S_SHIFT_DOWN: begin
                if (stat.ptr_inc_lt_cnt) begin
                    cmd.shift_down_step = 1'b1;
                end else begin
                    cmd.count_dec = 1'b1;
                    state_next    = iss_pkg::S_RESP;
                end
            end
            iss_pkg::S_READ: begin
                cmd.capture_read = 1'b1;
                state_next       = iss_pkg::S_RESP;
            end
            iss_pkg::S_FILL: begin
                if (stat.ptr_lt_tgt) begin
                    cmd.fill_step = 1'b1;
                end else begin
                    cmd.count_set_tgt = 1'b1;
                    state_next        = iss_pkg::S_RESP;
                end
            end
            iss_pkg::S_RESP: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = iss_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = iss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/iss_datapath.sv
// element store, count, pointer and result registers of the indexed sequence store
`default_nettype none

module iss_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [iss_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [iss_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [iss_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [iss_pkg::M_TUSER_W-1:0]      m_tuser,
    input  wire iss_pkg::cmd_t                 cmd,
    output iss_pkg::stat_t                     stat
);

    localparam int CW_RAW = $clog2(CAPACITY + 1);
    localparam int CNT_W  = (CW_RAW > iss_pkg::POS_W) ? CW_RAW : iss_pkg::POS_W;
    localparam int AW     = $clog2(CAPACITY);

    localparam int POS_LO = 0;
    localparam int VAL_LO = POS_LO + iss_pkg::POS_W;
    localparam int TGT_LO = VAL_LO + iss_pkg::VAL_W;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    // request registers
    logic [iss_pkg::REQ_W-1:0] req_type_reg;
    logic [CNT_W-1:0]          pos_reg;
    logic [iss_pkg::VAL_W-1:0] val_reg;
    logic [CNT_W-1:0]          tgt_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;

    // shift pipeline: a read issued in one cycle is written back in the next
    logic             pend_reg;
    logic [AW-1:0]    wr_addr_reg;

    logic [iss_pkg::VAL_W-1:0] mem [CAPACITY];
    logic [iss_pkg::VAL_W-1:0] rdata_reg;
    logic                      we;
    logic [AW-1:0]             wa;
    logic [iss_pkg::VAL_W-1:0] wd;
    logic                      re;
    logic [AW-1:0]             ra;

    logic [iss_pkg::VAL_W-1:0] res_val_reg;
    logic [iss_pkg::ST_W-1:0]  res_st_reg;
    logic                      m_tvalid_reg;
    logic [iss_pkg::VAL_W-1:0] out_val_reg;
    logic [iss_pkg::ST_W-1:0]  out_st_reg;
    logic [iss_pkg::POS_W-1:0] out_cnt_reg;

    logic [CNT_W-1:0] ptr_dec;
    logic [CNT_W-1:0] ptr_inc;

    assign ptr_dec = ptr_reg - ONE_C;
    assign ptr_inc = ptr_reg + ONE_C;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_type_reg <= s_tuser;
            pos_reg      <= CNT_W'(s_tdata[POS_LO +: iss_pkg::POS_W]);
            val_reg      <= s_tdata[VAL_LO +: iss_pkg::VAL_W];
            tgt_reg      <= CNT_W'(s_tdata[TGT_LO +: iss_pkg::POS_W]);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.count_clear) begin
            count_next = '0;
        end else if (cmd.count_set_tgt) begin
            count_next = tgt_reg;
        end else if (cmd.count_inc) begin
            count_next = count_reg + ONE_C;
        end else if (cmd.count_dec) begin
            count_next = count_reg - ONE_C;
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.load_ptr_count) begin
            ptr_next = count_reg;
        end else if (cmd.load_ptr_pos) begin
            ptr_next = pos_reg;
        end else if (cmd.shift_up_step) begin
            ptr_next = ptr_dec;
        end else if (cmd.shift_down_step || cmd.fill_step) begin
            ptr_next = ptr_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= cmd.shift_up_step || cmd.shift_down_step;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.shift_up_step || cmd.shift_down_step) begin
            wr_addr_reg <= ptr_reg[AW-1:0];
        end
    end

    // write port: pending shift write, then value write, then zero fill
    always_comb begin
        we = 1'b1;
        wa = pos_reg[AW-1:0];
        wd = val_reg;
        if (pend_reg) begin
            wa = wr_addr_reg;
            wd = rdata_reg;
        end else if (cmd.write_val) begin
            wa = pos_reg[AW-1:0];
            wd = val_reg;
        end else if (cmd.fill_step) begin
            wa = ptr_reg[AW-1:0];
            wd = '0;
        end else begin
            we = 1'b0;
        end
    end

    always_comb begin
        re = cmd.shift_up_step || cmd.shift_down_step || cmd.read_pos;
        ra = pos_reg[AW-1:0];
        if (cmd.shift_up_step) begin
            ra = ptr_dec[AW-1:0];
        end else if (cmd.shift_down_step) begin
            ra = ptr_inc[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rdata_reg <= mem[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_read) begin
            res_val_reg <= rdata_reg;
        end else if (cmd.set_result) begin
            res_val_reg <= '0;
        end
        if (cmd.set_result) begin
            res_st_reg <= cmd.status;
        end
        if (cmd.emit) begin
            out_val_reg <= res_val_reg;
            out_st_reg  <= res_st_reg;
            out_cnt_reg <= count_reg[iss_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_cnt_reg, out_val_reg};
    assign m_tuser  = out_st_reg;

    always_comb begin
        stat                = '0;
        stat.req_type       = req_type_reg;
        stat.pos_gt_cnt     = pos_reg > count_reg;
        stat.pos_ge_cnt     = pos_reg >= count_reg;
        stat.cnt_full       = count_reg >= CAP_C;
        stat.tgt_over       = tgt_reg > CAP_C;
        stat.tgt_gt_cnt     = tgt_reg > count_reg;
        stat.ptr_gt_pos     = ptr_reg > pos_reg;
        stat.ptr_inc_lt_cnt = ptr_inc < count_reg;
        stat.ptr_lt_tgt     = ptr_reg < tgt_reg;
        stat.out_free       = !m_tvalid_reg || m_tready;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("element count above capacity");

    a_write_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !(cmd.write_val || cmd.fill_step))
        else $error("shift write collides with another store write");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrites a beat not yet taken");

    a_shift_up_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_up_step |-> (ptr_reg > pos_reg && ptr_reg <= count_reg))
        else $error("shift up pointer outside the moved range");

endmodule

`default_nettype wire

// File: rtl/indexed_sequence_store_unit.sv
// top level of the indexed sequence store: controller and datapath
//
// holds an ordered sequence of up to CAPACITY signed 32-bit values and a count.
// each beat on the s_ channel is one request: s_tuser carries the request kind
// (insert, remove, get, set, resize, clear), s_tdata the position, value and
// target count. every request returns exactly one beat on the m_ channel with
// the value read (zero unless a get succeeds), a status (ok, out of range,
// full) and the element count after the request.
// one request is worked at a time. a request is decoded in the cycle after its
// beat is taken; get then passes through a read state before its result, while
// set, resize down, clear and failing requests go straight to their result.
// insert moves count - position entries up and remove moves count - position - 1
// entries down, one per cycle, through the element memory's single write port;
// growing writes one zero per cycle. the next beat can be taken in the cycle
// after the result is loaded. s_tready is high whenever no request is in work;
// a finished result sits in the output register, so the next request is taken
// while the receiver stalls, and its own result then waits until that register
// frees. reset empties the sequence and drops any pending result; the memory
// itself is not cleared, entries at or above the count are never read.
`default_nettype none

module indexed_sequence_store_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // position [6:0], item_value [38:7], target_count [45:39], zero pad
    input  wire logic [iss_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [2:0]
    input  wire logic [iss_pkg::S_TUSER_W-1:0] s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_value [31:0], element_count [38:32], zero pad
    output logic [iss_pkg::M_TDATA_W-1:0]      m_tdata,
    // status [1:0]
    output logic [iss_pkg::M_TUSER_W-1:0]      m_tuser
);

    iss_pkg::cmd_t  cmd;
    iss_pkg::stat_t stat;

    // state machine: steps each request kind through its sequence
    iss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, count, shift pointer and output register
    iss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire
